// File: rtl/l1u8_pkg.sv
// ----------------------------------------------------------------------------
// l1u8_pkg: shared types and codes for the Latin-1 / UTF-8 transcoder
// Holds the input op codes, the direction codes and the queue entry layout.
// ----------------------------------------------------------------------------
package l1u8_pkg;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // One queue entry carries all output bytes that one input item causes.
    typedef struct packed {
        logic       pair;    // second byte follows
        logic [7:0] byte1;   // second byte, valid when pair is set
        logic [7:0] byte0;   // first byte
    } entry_t;

endpackage

// File: rtl/l1u8_front.sv
// ----------------------------------------------------------------------------
// l1u8_front: accept and classify input bytes
// Keeps the decode sequence state and turns each accepted item into zero or
// one queue entry of one or two output bytes.
// ----------------------------------------------------------------------------
module l1u8_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             accept,
    input  logic             op,
    input  logic [7:0]       in_byte,
    output logic             push,
    output l1u8_pkg::entry_t push_entry
);
    import l1u8_pkg::*;

    logic       direction_reg;
    logic [1:0] pend_reg, pend_next;
    logic [7:0] acc_reg, acc_next;
    logic [7:0] acc_fold;
    logic       is_cont;
    logic       emit;
    entry_t     entry;

    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign acc_fold = {acc_reg[1:0], in_byte[5:0]};

    always_comb begin
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        emit        = 1'b0;
        entry.pair  = 1'b0;
        entry.byte0 = in_byte;
        entry.byte1 = {2'b10, in_byte[5:0]};
        if (op == OP_FLUSH) begin
            pend_next = 2'd0;
            acc_next  = 8'd0;
        end else if (direction_reg == DIR_ENCODE) begin
            pend_next = 2'd0;
            acc_next  = 8'd0;
            emit      = 1'b1;
            if (in_byte[7]) begin
                entry.pair  = 1'b1;
                entry.byte0 = {6'b110000, in_byte[7:6]};
            end
        end else if (pend_reg != 2'd0 && is_cont) begin
            // fold the continuation, finish when none remain
            pend_next = pend_reg - 2'd1;
            acc_next  = acc_fold;
            if (pend_reg == 2'd1) begin
                emit        = 1'b1;
                entry.byte0 = (acc_fold == 8'd0) ? 8'd1 : acc_fold;
                acc_next    = 8'd0;
            end
        end else begin
            // abandon any open sequence, treat byte as a new lead
            pend_next = 2'd0;
            acc_next  = 8'd0;
            if (!in_byte[7]) begin
                emit = 1'b1;
            end else if (in_byte[7:5] == 3'b110) begin
                pend_next = 2'd1;
                acc_next  = {3'b000, in_byte[4:0]};
            end else if (in_byte[7:4] == 4'b1110) begin
                pend_next = 2'd2;
                acc_next  = {4'b0000, in_byte[3:0]};
            end else if (in_byte[7:3] == 5'b11110) begin
                pend_next = 2'd3;
                acc_next  = {5'b00000, in_byte[2:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_ENCODE;
            pend_reg      <= 2'd0;
            acc_reg       <= 8'd0;
        end else if (cfg_wr_en) begin
            direction_reg <= cfg_wr_data;
            pend_reg      <= 2'd0;
            acc_reg       <= 8'd0;
        end else if (accept) begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
        end
    end

    assign push       = accept && emit;
    assign push_entry = entry;

    a_encode_no_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        direction_reg == DIR_ENCODE |-> pend_reg == 2'd0)
        else $error("sequence open in encode mode");
    a_idle_acc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 2'd0 |-> acc_reg == 8'd0)
        else $error("accumulator not clear with no sequence open");
    a_flush_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == OP_FLUSH |-> !push)
        else $error("flush produced output");
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == OP_FLUSH && !cfg_wr_en |=> pend_reg == 2'd0)
        else $error("flush left sequence open");

endmodule

// File: rtl/l1u8_queue.sv
// ----------------------------------------------------------------------------
// l1u8_queue: short entry queue between front and back
// Circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module l1u8_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  l1u8_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output l1u8_pkg::entry_t head
);
    import l1u8_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (empty || full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

// File: rtl/l1u8_back.sv
// ----------------------------------------------------------------------------
// l1u8_back: emit queued entries as output byte transfers
// Sends the first byte, then the second when the entry holds a pair.
// ----------------------------------------------------------------------------
module l1u8_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             empty,
    input  l1u8_pkg::entry_t head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import l1u8_pkg::*;

    logic half_reg, half_next;
    logic xfer;

    assign m_tvalid = !empty;
    assign m_tdata  = half_reg ? head.byte1 : head.byte0;
    assign m_tlast  = half_reg || !head.pair;
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && m_tlast;

    always_comb begin
        half_next = half_reg;
        if (xfer) begin
            half_next = !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= 1'b0;
        end else begin
            half_reg <= half_next;
        end
    end

    a_half_on_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> !empty && head.pair)
        else $error("second byte pending without a pair entry");
    a_half_after_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(half_reg) |-> $past(xfer) && $past(head.pair))
        else $error("second byte started without first transfer");
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> m_tlast && m_tready)
        else $error("entry released before its last byte");

endmodule

// File: rtl/latin1_utf8_transcoder_top.sv
// ----------------------------------------------------------------------------
// latin1_utf8_transcoder_top: Latin-1 / UTF-8 byte stream transcoder
// Front classifier, short entry queue and output byte emitter.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on the s_ channel while s_tready is
// high. With direction 0 it encodes Latin-1 to UTF-8: bytes below 0x80 pass
// as one output byte, higher bytes become a two-byte sequence (tlast on the
// second). With direction 1 it decodes UTF-8: ASCII passes through, multibyte
// sequences yield the low 8 bits of the code point (0 becomes 1) on their
// final continuation byte, stray continuations and leads 0xF8..0xFF are
// dropped, and a bad continuation abandons the open sequence and restarts
// on that byte. Setting s_tuser marks a flush: the open sequence is
// discarded and nothing is sent. Writing cfg_wr_data under cfg_wr_en sets
// the direction and also discards any open sequence; write it only while
// the block is idle. An item is classified in the cycle of its transfer; its
// entry is registered in the queue and offered on m_ after those ahead of it.
// Sustained rate is one input per cycle while m_tready is high, except that
// an encoded byte of 0x80 or above needs two transfers on the single output
// port, so a run of such bytes is paced by the output. The QUEUE_DEPTH-entry
// queue absorbs output stalls and keeps s_tready high while it has room.
// ----------------------------------------------------------------------------
module latin1_utf8_transcoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // direction: 0 encode, 1 decode
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] in_byte
    input  logic       s_tuser,       // [0] op: 0 data, 1 flush
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] out_byte
    output logic       m_tlast        // final byte caused by an input
);
    import l1u8_pkg::*;

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    entry_t q_head;

    // Hold input back only when the queue has no free entry.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Classify each transfer and update the decode sequence state.
    l1u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .op          (s_tuser),
        .in_byte     (s_tdata),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Decouple classification from output back-pressure.
    l1u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    // Advance through the bytes of the head entry.
    l1u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (q_empty),
        .head     (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("entry produced with queue full");
    a_out_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !q_empty)
        else $error("output valid without a queued entry");
    a_no_push_unaccepted: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> accept)
        else $error("entry produced without an accepted input");

endmodule

// File: dv/l1u8_stream_checker.sv
// ----------------------------------------------------------------------------
// l1u8_stream_checker: scoreboard for the Latin-1 / UTF-8 transcoder
// Watches the direction writes and both stream channels. It predicts the
// output bytes of every input transfer and compares each output transfer
// with the oldest predicted byte.
// ----------------------------------------------------------------------------
module l1u8_stream_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] in_byte
    input  logic       s_tuser,       // [0] op
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,       // [7:0] out_byte
    input  logic       m_tlast,
    output int         fail_count,
    output int         outstanding,
    output int         bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import l1u8_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_beat_t;

    out_beat_t  pending_bytes[$];
    logic       dir_mode;
    logic [1:0] cont_left;     // continuation bytes still owed by the open sequence
    logic [7:0] code_low;      // low 8 bits of the code point gathered so far

    initial begin
        fail_count    = 0;
        outstanding   = 0;
        bytes_checked = 0;
        dir_mode      = DIR_ENCODE;
        cont_left     = '0;
        code_low      = '0;
    end

    function automatic void drop_sequence();
        cont_left = '0;
        code_low  = '0;
    endfunction

    function automatic void queue_byte(input logic [7:0] value, input logic is_last);
        pending_bytes.push_back('{out_byte: value, last: is_last});
    endfunction

    function automatic void transcode_item(input logic op, input logic [7:0] b);
        if (op == OP_FLUSH) begin
            drop_sequence();
        end else if (dir_mode == DIR_ENCODE) begin
            drop_sequence();
            if (b < 8'h80) begin
                queue_byte(b, 1'b1);
            end else begin
                queue_byte(8'hC0 | (b >> 6), 1'b0);
                queue_byte(8'h80 | (b & 8'h3F), 1'b1);
            end
        end else if (cont_left != 0 && b[7:6] == 2'b10) begin
            code_low  = {code_low[1:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) begin
                queue_byte((code_low == 0) ? 8'h01 : code_low, 1'b1);
                code_low = '0;
            end
        end else begin
            // anything but a continuation abandons the open sequence and
            // is taken as a fresh lead
            drop_sequence();
            if (b < 8'h80) begin
                queue_byte(b, 1'b1);
            end else if (b < 8'hC0) begin
                // stray continuation: dropped
            end else if (b < 8'hE0) begin
                cont_left = 2'd1;
                code_low  = b & 8'h1F;
            end else if (b < 8'hF0) begin
                cont_left = 2'd2;
                code_low  = b & 8'h0F;
            end else if (b < 8'hF8) begin
                cont_left = 2'd3;
                code_low  = b & 8'h07;
            end
        end
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            pending_bytes.delete();
            dir_mode = DIR_ENCODE;
            drop_sequence();
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (pending_bytes.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected output byte, expected none, got %02h last %0b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = pending_bytes.pop_front();
                    if (want.out_byte !== m_tdata || want.last !== m_tlast) begin
                        fail_count++;
                        $display("%0t: output mismatch, expected %02h last %0b, got %02h last %0b",
                                 $time, want.out_byte, want.last, m_tdata, m_tlast);
                    end
                end
            end
            if (cfg_wr_en) begin
                dir_mode = cfg_wr_data;
                drop_sequence();
            end
            if (s_tvalid && s_tready)
                transcode_item(s_tuser, s_tdata);
        end
        outstanding = pending_bytes.size();
    end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the Latin-1 / UTF-8 transcoder
// Drives directed and random byte streams in both directions under four
// flow-control mixes. A separate scoreboard predicts and checks every
// output byte, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import l1u8_pkg::*;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'h00;   // [7:0] in_byte
    logic       s_tuser     = 1'b0;    // [0] op: 0 data, 1 flush
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;               // [7:0] out_byte
    logic       m_tlast;

    int fail_count;
    int outstanding;
    int bytes_checked;

    // Flow-control knobs, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int items_sent   = 0;
    int flushes_sent = 0;
    int cfg_writes   = 0;

    always #5 aclk = ~aclk;

    // Receiver: update tready on the falling edge so the DUT sees a stable
    // value at the next rising edge.
    always @(negedge aclk)
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);

    latin1_utf8_transcoder_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    l1u8_stream_checker scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .bytes_checked (bytes_checked)
    );

    // Present one item and hold it until the transfer. Called and returns at
    // a falling edge; tvalid stays high on return so back-to-back items need
    // no extra assignment in the same step.
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        if (op == OP_FLUSH)
            flushes_sent++;
    endtask

    // Stop sending, wait for every predicted byte, then idle so the block is quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Direction writes only happen with the block drained.
    task automatic write_direction(input logic dir);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    // Lead byte of an n+1 byte UTF-8 sequence with random payload bits.
    function automatic logic [7:0] utf8_lead(input int n);
        case (n)
            1:       return {3'b110, 5'($urandom)};
            2:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    initial begin
        logic [7:0] enc_bytes [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        logic [7:0] dec_bytes [21] = '{
            8'h41, 8'h00,                     // ASCII passes, zero included
            8'h80,                            // stray continuation
            8'hFF, 8'hF8,                     // invalid leads
            8'hC3, 8'hA9,                     // two-byte sequence
            8'hC0, 8'h80,                     // low bits zero, reported as 1
            8'hE2, 8'h82, 8'hAC,              // three-byte sequence
            8'hF0, 8'h9F, 8'h98, 8'h80,       // four-byte sequence
            8'hC3, 8'h41,                     // bad continuation, restart as ASCII
            8'hC3, 8'hE2, 8'h82               // bad continuation that opens a new lead
        };
        int         phase;
        int         quota;
        int         kind;
        int         n;
        int         k;
        logic [7:0] b;

        // Hold reset, then release it on a falling edge.
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed encode: range ends on both sides of 0x80, then a flush.
        write_direction(DIR_ENCODE);
        foreach (enc_bytes[i])
            send_item(OP_DATA, enc_bytes[i]);
        send_item(OP_FLUSH, 8'hA5);

        // Directed decode: the last sequence above is left open, so the
        // flush must discard it before the trailing ASCII byte.
        write_direction(DIR_DECODE);
        foreach (dec_bytes[i])
            send_item(OP_DATA, dec_bytes[i]);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_DATA, 8'h41);

        // Open a sequence and rewrite the direction: the write must discard
        // it, so the next continuation is stray.
        send_item(OP_DATA, 8'hE2);
        send_item(OP_DATA, 8'h82);
        write_direction(DIR_DECODE);
        send_item(OP_DATA, 8'hAC);
        send_item(OP_DATA, 8'h41);

        // Random part: alternate directions, step through the flow-control
        // mixes: none, sender idle, receiver stall, then both lightly.
        for (phase = 0; phase < 8; phase++) begin
            write_direction((phase % 2) ? DIR_DECODE : DIR_ENCODE);
            case (phase / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            quota = items_sent + 125;
            while (items_sent < quota) begin
                // Now and then let the output side empty completely.
                if ($urandom_range(0, 199) == 0)
                    drain();
                if (phase % 2 == 0) begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(OP_FLUSH, 8'($urandom));
                    else
                        send_item(OP_DATA, 8'($urandom));
                end else begin
                    kind = $urandom_range(0, 99);
                    if (kind < 20) begin
                        send_item(OP_DATA, 8'($urandom_range(0, 127)));
                    end else if (kind < 80) begin
                        // well-formed sequence with random payload
                        n = $urandom_range(1, 3);
                        send_item(OP_DATA, utf8_lead(n));
                        for (k = 0; k < n; k++)
                            send_item(OP_DATA, {2'b10, 6'($urandom)});
                    end else if (kind < 88) begin
                        // truncated sequence broken by a non-continuation
                        n = $urandom_range(1, 3);
                        send_item(OP_DATA, utf8_lead(n));
                        for (k = $urandom_range(0, n - 1); k > 0; k--)
                            send_item(OP_DATA, {2'b10, 6'($urandom)});
                        b = 8'($urandom);
                        if (b[7:6] == 2'b10)
                            b[6] = 1'b1;
                        send_item(OP_DATA, b);
                    end else if (kind < 94) begin
                        send_item(OP_DATA, 8'($urandom));
                    end else begin
                        send_item(OP_FLUSH, 8'($urandom));
                    end
                end
            end
        end

        // Drop the knobs, wait for the last bytes, then let the pipe settle.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("Covered %0d items (%0d flushes) over %0d direction writes in both directions",
                 items_sent, flushes_sent, cfg_writes);
        $display("and four flow-control mixes; %0d output bytes compared, %0d mismatches.",
                 bytes_checked, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout at %0t with %0d output bytes still outstanding", $time, outstanding);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/l1u8_pkg.sv
rtl/l1u8_front.sv
rtl/l1u8_queue.sv
rtl/l1u8_back.sv
rtl/latin1_utf8_transcoder_top.sv
dv/l1u8_stream_checker.sv
dv/tb_top.sv
